FILE: src/dbnms_pkg.sv
package dbnms_pkg;

  // Default capacity of the box store.
  localparam int MAX_DETS_DEF = 64;

  // One stored box: x_min, y_min, x_max, y_max, score, class from the lowest bit up.
  localparam int BOX_W = 88;
  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 8;
  localparam int THR_W = 16;

  // Field positions inside a stored box.
  localparam int XMIN_LSB = 0;
  localparam int YMIN_LSB = 16;
  localparam int XMAX_LSB = 32;
  localparam int YMAX_LSB = 48;
  localparam int SCORE_LSB = 64;
  localparam int CLASS_LSB = 80;

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_FIND_INIT,
    ST_FIND,
    ST_FIND_END,
    ST_EMIT,
    ST_SUP_INIT,
    ST_SUP,
    ST_EMIT_LAST,
    ST_EMIT_EMPTY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic scan_clr;
    logic issue;
    logic find_mode;
    logic sup_mode;
    logic commit;
    logic clear_set;
    logic emit_empty;
    logic emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
    logic found;
    logic have_prev;
    logic cnt_zero;
  } stat_t;

endpackage

FILE: src/detection_box_nms.sv
// Greedy class-aware non-maximum suppression. Boxes load at one transfer per cycle
// into a box store until a transfer with tlast; a box arriving with the store full
// is dropped and flags overflow on every result of the set. The set is then
// processed by repeated scans over the store: a selection scan picks the highest-score
// open box (lowest load index on ties), and a suppression scan runs every open box of
// the same class through the overlap pipeline. Each kept box leaves as one result
// transfer, and an empty set gives one result with valid_res low. No input is taken
// while a set is being processed.
module detection_box_nms #(
  parameter int MAX_DETS = dbnms_pkg::MAX_DETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // x_min, y_min, x_max, y_max, score, class
  input  logic [dbnms_pkg::BOX_W-1:0]  in_tdata,
  // has_box
  input  logic                         in_tuser,
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // kept_x_min, kept_y_min, kept_x_max, kept_y_max, kept_score, kept_class
  output logic [dbnms_pkg::BOX_W-1:0]  out_tdata,
  // valid_res, overflow
  output logic [1:0]                   out_tuser,
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [dbnms_pkg::THR_W-1:0]  cfg_wr_data
);

  dbnms_pkg::cmd_t  cmd;
  dbnms_pkg::stat_t stat;

  // Sequencing of load, selection, suppression and result transfers.
  dbnms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  // Box store, overlap arithmetic and result registers.
  dbnms_dp #(
    .MAX_DETS (MAX_DETS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tvalid   (in_tvalid),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

FILE: src/dbnms_ram.sv
module dbnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/dbnms_ctrl.sv
module dbnms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  input  logic              out_tready,
  input  dbnms_pkg::stat_t  stat,
  output dbnms_pkg::cmd_t   cmd,
  output logic              in_tready,
  output logic              out_tvalid
);

  dbnms_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dbnms_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      dbnms_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load_en = 1'b1;
        if (in_tvalid && in_tlast) begin
          state_nxt = dbnms_pkg::ST_START;
        end
      end
      dbnms_pkg::ST_START: begin
        if (stat.cnt_zero) begin
          state_nxt = dbnms_pkg::ST_EMIT_EMPTY;
        end else begin
          state_nxt = dbnms_pkg::ST_FIND_INIT;
        end
      end
      dbnms_pkg::ST_FIND_INIT: begin
        cmd.scan_clr = 1'b1;
        state_nxt = dbnms_pkg::ST_FIND;
      end
      dbnms_pkg::ST_FIND: begin
        cmd.find_mode = 1'b1;
        cmd.issue = !stat.scan_end;
        if (stat.scan_end && !stat.pipe_busy) begin
          state_nxt = dbnms_pkg::ST_FIND_END;
        end
      end
      dbnms_pkg::ST_FIND_END: begin
        if (!stat.found) begin
          state_nxt = dbnms_pkg::ST_EMIT_LAST;
        end else if (stat.have_prev) begin
          state_nxt = dbnms_pkg::ST_EMIT;
        end else begin
          cmd.commit = 1'b1;
          state_nxt = dbnms_pkg::ST_SUP_INIT;
        end
      end
      dbnms_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.commit = 1'b1;
          state_nxt = dbnms_pkg::ST_SUP_INIT;
        end
      end
      dbnms_pkg::ST_SUP_INIT: begin
        cmd.scan_clr = 1'b1;
        state_nxt = dbnms_pkg::ST_SUP;
      end
      dbnms_pkg::ST_SUP: begin
        cmd.sup_mode = 1'b1;
        cmd.issue = !stat.scan_end;
        if (stat.scan_end && !stat.pipe_busy) begin
          state_nxt = dbnms_pkg::ST_FIND_INIT;
        end
      end
      dbnms_pkg::ST_EMIT_LAST: begin
        out_tvalid = 1'b1;
        cmd.emit_last = 1'b1;
        if (out_tready) begin
          cmd.clear_set = 1'b1;
          state_nxt = dbnms_pkg::ST_LOAD;
        end
      end
      dbnms_pkg::ST_EMIT_EMPTY: begin
        out_tvalid = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.emit_empty = 1'b1;
        if (out_tready) begin
          cmd.clear_set = 1'b1;
          state_nxt = dbnms_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = dbnms_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: src/dbnms_dp.sv
module dbnms_dp #(
  parameter int MAX_DETS = dbnms_pkg::MAX_DETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dbnms_pkg::cmd_t               cmd,
  output dbnms_pkg::stat_t              stat,
  input  logic                          in_tvalid,
  input  logic [dbnms_pkg::BOX_W-1:0]   in_tdata,
  input  logic                          in_tuser,
  input  logic                          cfg_wr_en,
  input  logic [dbnms_pkg::THR_W-1:0]   cfg_wr_data,
  output logic [dbnms_pkg::BOX_W-1:0]   out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);

  localparam int AW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int CW = $clog2(MAX_DETS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DETS);

  logic [dbnms_pkg::THR_W-1:0] thr_r;
  logic [CW-1:0] cnt_r;
  logic dropped_r;
  logic [MAX_DETS-1:0] done_r;
  logic [CW-1:0] scan_r;
  logic found_r;
  logic have_prev_r;
  logic [dbnms_pkg::BOX_W-1:0] best_r;
  logic [AW-1:0] best_idx_r;
  logic [dbnms_pkg::BOX_W-1:0] prev_r;
  logic [dbnms_pkg::BOX_W-1:0] rdata;
  logic ram_we;

  // Pipeline stage registers.
  logic p1_v_r;
  logic [AW-1:0] p1_idx_r;
  logic s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [AW-1:0] s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;
  logic [15:0] iw_r, ih_r;
  logic signed [16:0] bw_r, bh_r;
  logic [31:0] inter3_r, inter4_r, inter5_r;
  logic signed [33:0] area_a_r, area_b_r;
  logic signed [35:0] uni_r;
  logic pos_r;
  logic [33:0] plo_r;
  logic [31:0] phi_r;

  // Fields of the current kept box and of the box read back.
  logic [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic [15:0] ix1, iy1, ix2, iy2;
  logic [dbnms_pkg::SCORE_W-1:0] rd_score, best_score;
  logic [dbnms_pkg::CLASS_W-1:0] rd_class, best_class;
  logic signed [16:0] aw, ah;
  logic elig;
  logic find_take;
  logic [49:0] lhs, rhs;
  logic sup_hit;
  logic load_xfer;

  assign ax1 = best_r[dbnms_pkg::XMIN_LSB +: 16];
  assign ay1 = best_r[dbnms_pkg::YMIN_LSB +: 16];
  assign ax2 = best_r[dbnms_pkg::XMAX_LSB +: 16];
  assign ay2 = best_r[dbnms_pkg::YMAX_LSB +: 16];
  assign bx1 = rdata[dbnms_pkg::XMIN_LSB +: 16];
  assign by1 = rdata[dbnms_pkg::YMIN_LSB +: 16];
  assign bx2 = rdata[dbnms_pkg::XMAX_LSB +: 16];
  assign by2 = rdata[dbnms_pkg::YMAX_LSB +: 16];
  assign rd_score = rdata[dbnms_pkg::SCORE_LSB +: dbnms_pkg::SCORE_W];
  assign rd_class = rdata[dbnms_pkg::CLASS_LSB +: dbnms_pkg::CLASS_W];
  assign best_score = best_r[dbnms_pkg::SCORE_LSB +: dbnms_pkg::SCORE_W];
  assign best_class = best_r[dbnms_pkg::CLASS_LSB +: dbnms_pkg::CLASS_W];

  assign load_xfer = cmd.load_en && in_tvalid;
  assign ram_we = load_xfer && in_tuser && (cnt_r < CNT_MAX);

  // Box store.
  dbnms_ram #(
    .WIDTH (dbnms_pkg::BOX_W),
    .DEPTH (MAX_DETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (scan_r[AW-1:0]),
    .rdata (rdata)
  );

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= dbnms_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Selection: the highest score among open boxes, lowest index on ties.
  assign find_take = p1_v_r && cmd.find_mode && !done_r[p1_idx_r] &&
                     (!found_r || (rd_score > best_score));

  // Intersection corners.
  assign ix1 = (ax1 > bx1) ? ax1 : bx1;
  assign iy1 = (ay1 > by1) ? ay1 : by1;
  assign ix2 = (ax2 < bx2) ? ax2 : bx2;
  assign iy2 = (ay2 < by2) ? ay2 : by2;
  assign elig = !done_r[p1_idx_r] && (rd_class == best_class);
  assign aw = $signed({1'b0, ax2}) - $signed({1'b0, ax1});
  assign ah = $signed({1'b0, ay2}) - $signed({1'b0, ay1});

  // Final compare: intersection * 65536 against threshold * union.
  assign lhs = {2'b00, inter5_r, 16'd0};
  assign rhs = {phi_r, 18'd0} + {16'd0, plo_r};
  assign sup_hit = s5_v_r && pos_r && (lhs > rhs);

  // Control state of the set: count, overflow, open flags, scan and pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      dropped_r <= 1'b0;
      done_r <= '0;
      scan_r <= '0;
      found_r <= 1'b0;
      have_prev_r <= 1'b0;
      p1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (ram_we) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (load_xfer && in_tuser) begin
        dropped_r <= 1'b1;
      end
      if (cmd.scan_clr) begin
        scan_r <= '0;
        found_r <= 1'b0;
      end else if (cmd.issue) begin
        scan_r <= scan_r + 1'b1;
      end
      if (find_take) begin
        found_r <= 1'b1;
      end
      if (cmd.commit) begin
        have_prev_r <= 1'b1;
        done_r[best_idx_r] <= 1'b1;
      end
      if (sup_hit) begin
        done_r[s5_idx_r] <= 1'b1;
      end
      p1_v_r <= cmd.issue;
      s2_v_r <= p1_v_r && cmd.sup_mode && elig;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      if (cmd.clear_set) begin
        cnt_r <= '0;
        dropped_r <= 1'b0;
        done_r <= '0;
        have_prev_r <= 1'b0;
      end
    end
  end

  // Payload: kept box, previous kept box and the overlap pipeline.
  always_ff @(posedge clk) begin
    p1_idx_r <= scan_r[AW-1:0];
    if (find_take) begin
      best_r <= rdata;
      best_idx_r <= p1_idx_r;
    end
    if (cmd.commit) begin
      prev_r <= best_r;
    end
    area_a_r <= aw * ah;
    // Widths of the overlap and of the second box.
    s2_idx_r <= p1_idx_r;
    iw_r <= (ix2 > ix1) ? (ix2 - ix1) : 16'd0;
    ih_r <= (iy2 > iy1) ? (iy2 - iy1) : 16'd0;
    bw_r <= $signed({1'b0, bx2}) - $signed({1'b0, bx1});
    bh_r <= $signed({1'b0, by2}) - $signed({1'b0, by1});
    // Areas.
    s3_idx_r <= s2_idx_r;
    inter3_r <= iw_r * ih_r;
    area_b_r <= bw_r * bh_r;
    // Union.
    s4_idx_r <= s3_idx_r;
    inter4_r <= inter3_r;
    uni_r <= 36'(area_a_r) + 36'(area_b_r) - $signed({4'd0, inter3_r});
    // Threshold times union in two partial products.
    s5_idx_r <= s4_idx_r;
    inter5_r <= inter4_r;
    pos_r <= (uni_r > 36'sd0);
    plo_r <= thr_r * uni_r[17:0];
    phi_r <= thr_r * uni_r[33:18];
  end

  assign stat.scan_end = (scan_r == cnt_r);
  assign stat.pipe_busy = p1_v_r || s2_v_r || s3_v_r || s4_v_r || s5_v_r;
  assign stat.found = found_r;
  assign stat.have_prev = have_prev_r;
  assign stat.cnt_zero = (cnt_r == '0);

  // Result fields.
  assign out_tdata = cmd.emit_empty ? '0 : prev_r;
  assign out_tuser = {dropped_r, !cmd.emit_empty};
  assign out_tlast = cmd.emit_last;

endmodule

FILE: tb/detection_box_nms_test.sv
`timescale 1ns / 1ps

module detection_box_nms_test;

  localparam int CAP = dbnms_pkg::MAX_DETS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;

  // One candidate box as it travels on the input channel.
  typedef struct {
    bit        has_box;
    bit [15:0] x1, y1, x2, y2, score;
    bit [7:0]  cls;
    bit        last;
  } box_item_t;

  // One result of a set.
  typedef struct {
    bit        valid;
    bit [15:0] x1, y1, x2, y2, score;
    bit [7:0]  cls;
    bit        ovf;
    bit        last;
  } kept_box_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [dbnms_pkg::BOX_W-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [dbnms_pkg::BOX_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 0;
  logic [dbnms_pkg::THR_W-1:0] cfg_wr_data = '0;

  box_item_t pending_boxes[$];
  kept_box_t expected_kept[$];
  int error_count = 0;
  longint cycle_count = 0;

  // Predictor state.
  bit [15:0] pred_thr;
  box_item_t set_boxes[$];
  bit set_dropped;

  detection_box_nms DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Exact overlap test: intersection*65536 > threshold*union, union positive.
  function automatic bit overlap_exceeds(input box_item_t a, input box_item_t b);
    longint ix1, iy1, ix2, iy2, iw, ih, inter, area_a, area_b, uni;
    ix1 = (a.x1 > b.x1) ? a.x1 : b.x1;
    iy1 = (a.y1 > b.y1) ? a.y1 : b.y1;
    ix2 = (a.x2 < b.x2) ? a.x2 : b.x2;
    iy2 = (a.y2 < b.y2) ? a.y2 : b.y2;
    iw = (ix2 - ix1 > 0) ? ix2 - ix1 : 0;
    ih = (iy2 - iy1 > 0) ? iy2 - iy1 : 0;
    inter = iw * ih;
    area_a = (longint'(a.x2) - longint'(a.x1)) * (longint'(a.y2) - longint'(a.y1));
    area_b = (longint'(b.x2) - longint'(b.x1)) * (longint'(b.y2) - longint'(b.y1));
    uni = area_a + area_b - inter;
    if (uni <= 0) return 0;
    return inter * 65536 > longint'(pred_thr) * uni;
  endfunction

  // Track one accepted box and, at the end of a set, queue its kept boxes.
  task automatic predict_nms(input box_item_t it);
    int order[$];
    bit gone[CAP];
    kept_box_t r;
    int n, pos, kept_cnt;
    if (it.has_box) begin
      if (set_boxes.size() < CAP) set_boxes.insert(set_boxes.size(), it);
      else set_dropped = 1;
    end
    if (!it.last) return;
    n = set_boxes.size();
    if (n == 0) begin
      r = '{default: 0};
      r.ovf = set_dropped;
      r.last = 1;
      expected_kept.insert(expected_kept.size(), r);
    end else begin
      // Stable order by descending score.
      for (int i = 0; i < n; i++) begin
        pos = order.size();
        while (pos > 0 && set_boxes[order[pos-1]].score < set_boxes[i].score) pos--;
        order.insert(pos, i);
      end
      for (int i = 0; i < CAP; i++) gone[i] = 0;
      kept_cnt = 0;
      for (int i = 0; i < n; i++) begin
        if (gone[order[i]]) continue;
        r.valid = 1;
        r.x1 = set_boxes[order[i]].x1; r.y1 = set_boxes[order[i]].y1;
        r.x2 = set_boxes[order[i]].x2; r.y2 = set_boxes[order[i]].y2;
        r.score = set_boxes[order[i]].score; r.cls = set_boxes[order[i]].cls;
        r.ovf = set_dropped; r.last = 0;
        expected_kept.insert(expected_kept.size(), r);
        kept_cnt++;
        for (int j = i + 1; j < n; j++) begin
          if (gone[order[j]] || set_boxes[order[j]].cls != set_boxes[order[i]].cls) continue;
          if (overlap_exceeds(set_boxes[order[i]], set_boxes[order[j]])) gone[order[j]] = 1;
        end
      end
      expected_kept[$].last = 1;
    end
    set_boxes.delete();
    set_dropped = 0;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input driver: presents queued boxes with random gaps.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_nms(pending_boxes.pop_front());
      if (in_tvalid && !in_tready) begin
        // hold the current transfer
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 0;
      end else if (pending_boxes.size() > 0) begin
        in_tvalid <= 1;
        in_tdata <= {pending_boxes[0].cls, pending_boxes[0].score, pending_boxes[0].y2,
                     pending_boxes[0].x2, pending_boxes[0].y1, pending_boxes[0].x1};
        in_tuser <= pending_boxes[0].has_box;
        in_tlast <= pending_boxes[0].last;
        in_gap <= gap_len();
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // Result monitor with random stalls.
  int out_gap = 0;
  always @(posedge clk) begin
    kept_box_t w;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_kept.size() == 0) begin
          report("unexpected result", out_tdata[63:0], 0);
        end else begin
          w = expected_kept.pop_front();
          if (out_tuser[0] !== w.valid) report("valid_res", out_tuser[0], w.valid);
          if (out_tdata[15:0] !== w.x1) report("kept_x_min", out_tdata[15:0], w.x1);
          if (out_tdata[31:16] !== w.y1) report("kept_y_min", out_tdata[31:16], w.y1);
          if (out_tdata[47:32] !== w.x2) report("kept_x_max", out_tdata[47:32], w.x2);
          if (out_tdata[63:48] !== w.y2) report("kept_y_max", out_tdata[63:48], w.y2);
          if (out_tdata[79:64] !== w.score) report("kept_score", out_tdata[79:64], w.score);
          if (out_tdata[87:80] !== w.cls) report("kept_class", out_tdata[87:80], w.cls);
          if (out_tuser[1] !== w.ovf) report("overflow", out_tuser[1], w.ovf);
          if (out_tlast !== w.last) report("last_result", out_tlast, w.last);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        out_gap <= gap_len();
      end
    end
  end

  function automatic box_item_t make_box(input bit [7:0] cls, input bit last);
    box_item_t b;
    bit [15:0] cx, cy;
    b.has_box = 1;
    b.cls = cls;
    b.last = last;
    b.score = $urandom_range(0, 99) < 15 ? 16'h4000 : 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      b.x1 = 16'($urandom); b.y1 = 16'($urandom);
      b.x2 = 16'($urandom); b.y2 = 16'($urandom);
    end else begin
      // Clustered boxes so that overlaps are common.
      cx = 16'($urandom_range(200, 1200));
      cy = 16'($urandom_range(200, 1200));
      b.x1 = cx - 16'($urandom_range(0, 200)); b.x2 = cx + 16'($urandom_range(0, 200));
      b.y1 = cy - 16'($urandom_range(0, 200)); b.y2 = cy + 16'($urandom_range(0, 200));
    end
    return b;
  endfunction

  task automatic drain_and_idle();
    while (pending_boxes.size() > 0 || in_tvalid || expected_kept.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(input bit [15:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    pred_thr = v;
    @(posedge clk);
  endtask

  task automatic add_set(input int n, input int ncls);
    for (int i = 0; i < n; i++)
      pending_boxes.insert(pending_boxes.size(),
                           make_box(8'($urandom_range(0, ncls - 1)), i == n - 1));
  endtask

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** detection_box_nms: FAILED **");
      $finish;
    end
  end

  initial begin
    box_item_t b;
    bit [15:0] thr_list[5];
    pred_thr = dbnms_pkg::THR_RESET;
    set_dropped = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed sets at the reset threshold.
    b = '{has_box: 0, last: 1, default: 0};
    pending_boxes.insert(pending_boxes.size(), b);   // empty set
    b = '{has_box: 0, last: 0, default: 0};
    pending_boxes.insert(pending_boxes.size(), b);   // ignored marker
    b = '{has_box: 1, x1: 16'hFFFF, y1: 16'hFFFF, x2: 16'hFFFF, y2: 16'hFFFF,
          score: 16'hFFFF, cls: 8'hFF, last: 0};
    pending_boxes.insert(pending_boxes.size(), b);
    b = '{has_box: 1, x1: 0, y1: 0, x2: 16'hFFFF, y2: 16'hFFFF,
          score: 16'hFFFF, cls: 8'hFF, last: 0};
    pending_boxes.insert(pending_boxes.size(), b);
    b = '{has_box: 1, x1: 0, y1: 0, x2: 16'hFFFF, y2: 16'hFFFF,
          score: 0, cls: 8'hFF, last: 0};
    pending_boxes.insert(pending_boxes.size(), b);   // same box, suppressed
    b = '{has_box: 1, x1: 100, y1: 100, x2: 10, y2: 10,
          score: 16'h8000, cls: 0, last: 0};
    pending_boxes.insert(pending_boxes.size(), b);   // inverted corners
    b = '{has_box: 1, x1: 20, y1: 20, x2: 50, y2: 50,
          score: 16'h8000, cls: 0, last: 0};
    pending_boxes.insert(pending_boxes.size(), b);
    b = '{has_box: 0, last: 1, default: 0};
    pending_boxes.insert(pending_boxes.size(), b);   // marker ends a non-empty set
    drain_and_idle();

    // Overfilled set ended by a marker, then an overfilled set ended by a box.
    for (int i = 0; i < CAP + 3; i++)
      pending_boxes.insert(pending_boxes.size(), make_box(8'(i % 4), 0));
    b = '{has_box: 0, last: 1, default: 0};
    pending_boxes.insert(pending_boxes.size(), b);
    for (int i = 0; i < CAP + 1; i++)
      pending_boxes.insert(pending_boxes.size(), make_box(8'(i % 2), 0));
    pending_boxes.insert(pending_boxes.size(), make_box(0, 1));
    drain_and_idle();

    // Random phases over several thresholds, extremes included.
    thr_list = '{16'd0, 16'hFFFF, 16'd32768, 16'd16384, dbnms_pkg::THR_RESET};
    foreach (thr_list[k]) begin
      write_threshold(thr_list[k]);
      for (int s = 0; s < 8; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          b = '{has_box: 0, last: 1'($urandom_range(0, 1)), default: 0};
          pending_boxes.insert(pending_boxes.size(), b);
        end
        add_set($urandom_range(1, 16), $urandom_range(1, 3));
      end
      drain_and_idle();
    end

    if (error_count == 0) begin
      $display("** detection_box_nms: PASSED **");
    end else begin
      $display("** detection_box_nms: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/dbnms_pkg.sv
src/dbnms_ram.sv
src/dbnms_ctrl.sv
src/dbnms_dp.sv
src/detection_box_nms.sv
tb/detection_box_nms_test.sv
